>>> rtl/lpd_pkg.sv
// shared types and constants for the length-prefix deframer
`default_nettype none

package lpd_pkg;

    localparam int HEADER_BYTES_DEF = 4;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd65532;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PASS   = 2'd1,
        PH_DROP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_BYTE_LAST = 2'd1,
        KIND_EMPTY     = 2'd2,
        KIND_DROP      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_token_xfer;

endpackage

`default_nettype wire

>>> rtl/lpd_front.sv
// front end: header parsing, payload counting and result classification
`default_nettype none

module lpd_front #(
    parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_wdata,
    output lpd_pkg::t_token_xfer      o_xfer
);

    localparam int LEN_W = 8 * HEADER_BYTES;

    lpd_pkg::t_phase   r_phase, n_phase;
    logic [1:0]        r_hcnt, n_hcnt;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [15:0]       r_max;

    logic [LEN_W-1:0]  len_base;
    logic [LEN_W-1:0]  len_built;
    logic              hdr_done;
    logic              left_last;
    logic              oversize;

    assign len_base  = (r_hcnt == 2'd0) ? '0 : r_len;
    assign len_built = (len_base << 8) | LEN_W'(i_data_byte);
    assign hdr_done  = (r_hcnt == 2'(HEADER_BYTES - 1));
    assign left_last = (r_left == LEN_W'(1));
    assign oversize  = (32'(len_built) > 32'(r_max));

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            lpd_pkg::PH_PASS, lpd_pkg::PH_DROP: begin
                if (i_accept && left_last) begin
                    n_phase = lpd_pkg::PH_HEADER;
                end
            end
            default: begin
                if (i_accept && hdr_done) begin
                    if (len_built == '0) begin
                        n_phase = lpd_pkg::PH_HEADER;
                    end else if (oversize) begin
                        n_phase = lpd_pkg::PH_DROP;
                    end else begin
                        n_phase = lpd_pkg::PH_PASS;
                    end
                end
            end
        endcase
    end

    // counters and result token
    always_comb begin
        n_hcnt = r_hcnt;
        n_len  = r_len;
        n_left = r_left;
        o_xfer = '{valid: 1'b0, token: '{kind: lpd_pkg::KIND_BYTE, data: i_data_byte}};
        case (r_phase)
            lpd_pkg::PH_PASS: begin
                if (i_accept) begin
                    n_left = r_left - LEN_W'(1);
                    o_xfer.valid = 1'b1;
                    o_xfer.token.kind = left_last ? lpd_pkg::KIND_BYTE_LAST
                                                  : lpd_pkg::KIND_BYTE;
                end
            end
            lpd_pkg::PH_DROP: begin
                if (i_accept) begin
                    n_left = r_left - LEN_W'(1);
                    if (left_last) begin
                        o_xfer.valid = 1'b1;
                        o_xfer.token.kind = lpd_pkg::KIND_DROP;
                    end
                end
            end
            default: begin
                if (i_accept) begin
                    n_len = len_built;
                    if (hdr_done) begin
                        n_hcnt = 2'd0;
                        n_left = len_built;
                        if (len_built == '0) begin
                            o_xfer.valid = 1'b1;
                            o_xfer.token.kind = lpd_pkg::KIND_EMPTY;
                        end
                    end else begin
                        n_hcnt = r_hcnt + 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpd_pkg::PH_HEADER;
            r_hcnt  <= 2'd0;
            r_len   <= '0;
            r_left  <= '0;
            r_max   <= lpd_pkg::MAX_PAYLOAD_RST;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_len   <= n_len;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/lpd_queue.sv
// short token queue between the front end and the output stage
`default_nettype none

module lpd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpd_pkg::t_token_xfer i_wr,
    input  wire logic                 i_rd,
    output lpd_pkg::t_token           o_rd_token,
    output logic                      o_full,
    output logic                      o_avail
);

    localparam int QD = lpd_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    lpd_pkg::t_token r_mem [QD];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full     = (r_count == CW'(QD));
    assign o_avail    = (r_count != '0);
    assign o_rd_token = r_mem[r_rptr];
    assign do_wr      = i_wr.valid && !o_full;
    assign do_rd      = i_rd && o_avail;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PW'(QD - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PW'(QD - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lpd_back.sv
// output stage: decodes tokens into result fields and holds the result register
`default_nettype none

module lpd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpd_pkg::t_token      i_token,
    input  wire logic                 i_avail,
    output logic                      o_take,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [7:0]                o_payload_byte,
    output logic                      o_frame_end,
    output logic [1:0]                o_status
);

    logic             r_valid, n_valid;
    logic [7:0]       r_byte, n_byte;
    logic             r_end, n_end;
    lpd_pkg::t_status r_status, n_status;
    logic             out_xfer;

    assign empty    = !r_valid;
    assign out_xfer = pop && r_valid;
    assign o_take   = i_avail && (!r_valid || out_xfer);

    // token decode
    always_comb begin
        n_byte   = 8'd0;
        n_end    = 1'b1;
        n_status = lpd_pkg::ST_BYTE;
        case (i_token.kind)
            lpd_pkg::KIND_BYTE: begin
                n_byte = i_token.data;
                n_end  = 1'b0;
            end
            lpd_pkg::KIND_BYTE_LAST: begin
                n_byte = i_token.data;
            end
            lpd_pkg::KIND_EMPTY: begin
                n_status = lpd_pkg::ST_EMPTY;
            end
            lpd_pkg::KIND_DROP: begin
                n_status = lpd_pkg::ST_DROPPED;
            end
            default: begin
                n_status = lpd_pkg::ST_BYTE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (out_xfer) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_byte   <= n_byte;
            r_end    <= n_end;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_payload_byte = r_byte;
    assign o_frame_end    = r_end;
    assign o_status       = r_status;

endmodule

`default_nettype wire

>>> rtl/length_prefix_deframer.sv
// top level of the length-prefix deframer
`default_nettype none

// Takes one received byte per cycle (push while full is low) and splits the
// stream into frames of a HEADER_BYTES big-endian length and that many
// payload bytes. Payload of frames no longer than max_payload is streamed out
// one result per byte, last byte marked with frame_end; a zero length gives
// one empty-frame result, a longer frame one dropped result on its last byte.
// Every byte is counted in the front end's counters; a result reaches the
// outputs through a two-entry token queue and the output register. full
// rises only when the queue holds two tokens, i.e. when the receiver holds
// off. No clearing pass after reset. max_payload is written through
// i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module length_prefix_deframer #(
    parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_end,
    output logic [1:0]       o_status
);

    lpd_pkg::t_token_xfer front_xfer;
    lpd_pkg::t_token      q_token;
    logic                 q_avail;
    logic                 q_take;
    logic                 in_xfer;

    assign in_xfer = push && !full;

    lpd_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_xfer      (front_xfer)
    );

    lpd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (front_xfer),
        .i_rd       (q_take),
        .o_rd_token (q_token),
        .o_full     (full),
        .o_avail    (q_avail)
    );

    lpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (q_token),
        .i_avail        (q_avail),
        .o_take         (q_take),
        .pop            (pop),
        .empty          (empty),
        .o_payload_byte (o_payload_byte),
        .o_frame_end    (o_frame_end),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire
